>>> sv/node_record_bit_stuffing_packer_unit_macros.svh
// Assertion macros used by the node record packer's byte packer module.
`ifndef NODE_RECORD_BIT_STUFFING_PACKER_UNIT_MACROS_SVH
`define NODE_RECORD_BIT_STUFFING_PACKER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NRBSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define NRBSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/nrbsp_pkg.sv
// Shared types, constants and helpers for the node record bit stuffing packer.
package nrbsp_pkg;

    // Significant width of the count field.
    localparam int CountWidth = 32;
    // A one is stuffed after this many zeros in a row.
    localparam int StuffRun   = 3;
    // Zero bits that close every record.
    localparam int TermZeros  = 4;
    localparam int ByteBits   = 8;
    localparam int BranchBits = 3;
    localparam int CodeBits   = 2;

    localparam int IdxW  = $clog2(TermZeros);
    localparam int ZrunW = $clog2(StuffRun);
    localparam int LenW  = $clog2(ByteBits);

    typedef logic [CountWidth-1:0] t_count;
    typedef logic [IdxW-1:0]       t_idx;
    typedef logic [ZrunW-1:0]      t_zrun;
    typedef logic [LenW-1:0]       t_len;
    typedef logic [ByteBits-1:0]   t_byte;
    typedef logic [ByteBits-2:0]   t_acc;
    typedef logic [BranchBits-1:0] t_branch;
    typedef logic [CodeBits-1:0]   t_code;

    // Record sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_BRANCH,
        S_CODE,
        S_COUNT,
        S_STUFF,
        S_TERM,
        S_END,
        S_FLUSH
    } t_state;

    // What the sequencer hands the byte packer in one cycle.
    typedef enum logic [1:0] {
        CMD_BIT,
        CMD_END,
        CMD_FLUSH
    } t_cmd_kind;

    typedef struct packed {
        logic      valid;
        t_cmd_kind kind;
        logic      bit_val;
        logic      bad;
    } t_pk_cmd;

    // Base letter to 2-bit code; anything unknown maps to the T code.
    function automatic t_code base_code(input logic [7:0] ch);
        t_code code;
        case (ch)
            8'h41, 8'h61: code = 2'd0;
            8'h43, 8'h63: code = 2'd1;
            8'h47, 8'h67: code = 2'd2;
            default:      code = 2'd3;
        endcase
        return code;
    endfunction

endpackage

>>> sv/nrbsp_seq.sv
// Record sequencer: walks one record out as a bit stream, one bit per cycle while the packer accepts it.
module nrbsp_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_valid,
    output logic                o_s_ready,
    input  logic                i_req_type,
    input  nrbsp_pkg::t_branch  i_branch,
    input  logic [7:0]          i_label,
    input  logic [31:0]         i_count,
    output nrbsp_pkg::t_pk_cmd  o_cmd,
    input  logic                i_cmd_ready
);

    nrbsp_pkg::t_state  r_state, n_state;
    nrbsp_pkg::t_branch r_br;
    nrbsp_pkg::t_code   r_code;
    nrbsp_pkg::t_count  r_cnt;
    nrbsp_pkg::t_idx    r_idx;
    nrbsp_pkg::t_zrun   r_zeros;
    logic               r_bad;

    nrbsp_pkg::t_count  w_masked;
    nrbsp_pkg::t_count  w_cnt_shr;
    logic               w_step;
    logic               w_zrun_hit;

    assign w_masked   = nrbsp_pkg::t_count'(i_count);
    assign w_cnt_shr  = r_cnt >> 1;
    assign w_step     = o_cmd.valid && i_cmd_ready;
    // Current count bit is a zero that completes a run
    assign w_zrun_hit = !r_cnt[0] &&
                        (r_zeros == nrbsp_pkg::t_zrun'(nrbsp_pkg::StuffRun - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            nrbsp_pkg::S_IDLE: begin
                if (i_s_valid) begin
                    n_state = i_req_type ? nrbsp_pkg::S_FLUSH : nrbsp_pkg::S_BRANCH;
                end
            end
            nrbsp_pkg::S_BRANCH: begin
                if (i_cmd_ready &&
                    r_idx == nrbsp_pkg::t_idx'(nrbsp_pkg::BranchBits - 1)) begin
                    n_state = nrbsp_pkg::S_CODE;
                end
            end
            nrbsp_pkg::S_CODE: begin
                if (i_cmd_ready &&
                    r_idx == nrbsp_pkg::t_idx'(nrbsp_pkg::CodeBits - 1)) begin
                    n_state = nrbsp_pkg::S_COUNT;
                end
            end
            nrbsp_pkg::S_COUNT: begin
                if (i_cmd_ready) begin
                    if (w_zrun_hit) begin
                        n_state = nrbsp_pkg::S_STUFF;
                    end else if (w_cnt_shr == '0) begin
                        n_state = nrbsp_pkg::S_TERM;
                    end
                end
            end
            nrbsp_pkg::S_STUFF: begin
                // the top count bit is a one, so count bits always follow a stuff
                if (i_cmd_ready) begin
                    n_state = nrbsp_pkg::S_COUNT;
                end
            end
            nrbsp_pkg::S_TERM: begin
                if (i_cmd_ready &&
                    r_idx == nrbsp_pkg::t_idx'(nrbsp_pkg::TermZeros - 1)) begin
                    n_state = nrbsp_pkg::S_END;
                end
            end
            nrbsp_pkg::S_END, nrbsp_pkg::S_FLUSH: begin
                if (i_cmd_ready) begin
                    n_state = nrbsp_pkg::S_IDLE;
                end
            end
            default: n_state = nrbsp_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_s_ready     = 1'b0;
        o_cmd.valid   = 1'b1;
        o_cmd.kind    = nrbsp_pkg::CMD_BIT;
        o_cmd.bit_val = 1'b0;
        o_cmd.bad     = r_bad;
        case (r_state)
            nrbsp_pkg::S_IDLE: begin
                o_s_ready   = 1'b1;
                o_cmd.valid = 1'b0;
            end
            nrbsp_pkg::S_BRANCH: o_cmd.bit_val = r_br[0];
            nrbsp_pkg::S_CODE:   o_cmd.bit_val = r_code[0];
            nrbsp_pkg::S_COUNT:  o_cmd.bit_val = r_cnt[0];
            nrbsp_pkg::S_STUFF:  o_cmd.bit_val = 1'b1;
            nrbsp_pkg::S_TERM:   o_cmd.bit_val = 1'b0;
            nrbsp_pkg::S_END:    o_cmd.kind    = nrbsp_pkg::CMD_END;
            nrbsp_pkg::S_FLUSH: begin
                o_cmd.kind = nrbsp_pkg::CMD_FLUSH;
                o_cmd.bad  = 1'b0;
            end
            default:             o_cmd.valid   = 1'b0;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nrbsp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Field shift registers and step counters
    always_ff @(posedge i_clk) begin
        if (r_state == nrbsp_pkg::S_IDLE) begin
            if (i_s_valid) begin
                r_br    <= i_branch;
                r_code  <= nrbsp_pkg::base_code(i_label);
                r_idx   <= '0;
                r_zeros <= '0;
                // a zero count goes out as one and is flagged
                if (w_masked == '0) begin
                    r_cnt <= nrbsp_pkg::t_count'(1);
                    r_bad <= 1'b1;
                end else begin
                    r_cnt <= w_masked;
                    r_bad <= 1'b0;
                end
            end
        end else if (w_step) begin
            r_idx <= (n_state != r_state) ? '0 : r_idx + 1'b1;
            case (r_state)
                nrbsp_pkg::S_BRANCH: r_br   <= r_br >> 1;
                nrbsp_pkg::S_CODE:   r_code <= r_code >> 1;
                nrbsp_pkg::S_COUNT: begin
                    r_cnt   <= w_cnt_shr;
                    r_zeros <= (r_cnt[0] || w_zrun_hit) ? '0 : r_zeros + 1'b1;
                end
                default: r_zeros <= r_zeros;
            endcase
        end
    end

endmodule

>>> sv/nrbsp_pack.sv
// Byte packer: gathers stream bits MSB first, holds the newest byte, drives the output register.
`include "node_record_bit_stuffing_packer_unit_macros.svh"

module nrbsp_pack (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nrbsp_pkg::t_pk_cmd  i_cmd,
    output logic                o_cmd_ready,
    output logic                o_m_valid,
    input  logic                i_m_ready,
    output nrbsp_pkg::t_byte    o_m_byte,
    output logic                o_m_last,
    output logic                o_m_bad
);

    localparam nrbsp_pkg::t_len LenFull = nrbsp_pkg::t_len'(nrbsp_pkg::ByteBits - 1);

    nrbsp_pkg::t_acc  r_acc, n_acc;
    nrbsp_pkg::t_len  r_len, n_len;
    logic             r_hold_vld, n_hold_vld;
    nrbsp_pkg::t_byte r_hold_byte, n_hold_byte;
    logic             r_hold_bad, n_hold_bad;
    logic             r_out_vld, n_out_vld;
    nrbsp_pkg::t_byte r_out_byte, n_out_byte;
    logic             r_out_last, n_out_last;
    logic             r_out_bad, n_out_bad;

    logic               w_out_free;
    logic               w_fire;
    nrbsp_pkg::t_byte   w_full_byte;
    nrbsp_pkg::t_byte   w_flush_byte;
    logic [nrbsp_pkg::LenW:0] w_pad_shift;

    assign w_out_free   = !r_out_vld || i_m_ready;
    assign w_full_byte  = {r_acc, i_cmd.bit_val};
    assign w_pad_shift  = (nrbsp_pkg::LenW + 1)'(nrbsp_pkg::ByteBits) - {1'b0, r_len};
    assign w_flush_byte = {1'b0, r_acc} << w_pad_shift;

    // A request stalls only when it must move a byte into a busy output register
    always_comb begin
        case (i_cmd.kind)
            nrbsp_pkg::CMD_BIT:   o_cmd_ready = !(r_len == LenFull && r_hold_vld) || w_out_free;
            nrbsp_pkg::CMD_END:   o_cmd_ready = !r_hold_vld || w_out_free;
            nrbsp_pkg::CMD_FLUSH: o_cmd_ready = (r_len == '0) || w_out_free;
            default:              o_cmd_ready = 1'b1;
        endcase
    end

    assign w_fire = i_cmd.valid && o_cmd_ready;

    // Next values of accumulator, hold stage and output register
    always_comb begin
        n_acc       = r_acc;
        n_len       = r_len;
        n_hold_vld  = r_hold_vld;
        n_hold_byte = r_hold_byte;
        n_hold_bad  = r_hold_bad;
        n_out_vld   = r_out_vld && !i_m_ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_bad   = r_out_bad;
        if (w_fire) begin
            case (i_cmd.kind)
                nrbsp_pkg::CMD_BIT: begin
                    if (r_len == LenFull) begin
                        // byte complete: older held byte goes out, not the last one
                        n_acc       = '0;
                        n_len       = '0;
                        n_hold_vld  = 1'b1;
                        n_hold_byte = w_full_byte;
                        n_hold_bad  = i_cmd.bad;
                        if (r_hold_vld) begin
                            n_out_vld  = 1'b1;
                            n_out_byte = r_hold_byte;
                            n_out_last = 1'b0;
                            n_out_bad  = r_hold_bad;
                        end
                    end else begin
                        n_acc = {r_acc[nrbsp_pkg::ByteBits-3:0], i_cmd.bit_val};
                        n_len = r_len + 1'b1;
                    end
                end
                nrbsp_pkg::CMD_END: begin
                    // final byte of the record is marked last
                    if (r_hold_vld) begin
                        n_out_vld  = 1'b1;
                        n_out_byte = r_hold_byte;
                        n_out_last = 1'b1;
                        n_out_bad  = r_hold_bad;
                        n_hold_vld = 1'b0;
                    end
                end
                nrbsp_pkg::CMD_FLUSH: begin
                    if (r_len != '0) begin
                        n_out_vld  = 1'b1;
                        n_out_byte = w_flush_byte;
                        n_out_last = 1'b1;
                        n_out_bad  = 1'b0;
                        n_acc      = '0;
                        n_len      = '0;
                    end
                end
                default: n_len = r_len;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_len      <= '0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_acc      <= n_acc;
            r_len      <= n_len;
            r_hold_vld <= n_hold_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_hold_byte <= n_hold_byte;
        r_hold_bad  <= n_hold_bad;
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
        r_out_bad   <= n_out_bad;
    end

    assign o_m_valid = r_out_vld;
    assign o_m_byte  = r_out_byte;
    assign o_m_last  = r_out_last;
    assign o_m_bad   = r_out_bad;

    // Checks
    `NRBSP_ASSERT_NEXT(a_byte_held, w_fire && i_cmd.kind == nrbsp_pkg::CMD_BIT && r_len == LenFull, r_hold_vld && r_len == '0, "completed byte not held")
    `NRBSP_ASSERT_NEXT(a_end_drains, w_fire && i_cmd.kind == nrbsp_pkg::CMD_END, !r_hold_vld, "hold stage not drained at record end")
    `NRBSP_ASSERT_NEXT(a_flush_out, w_fire && i_cmd.kind == nrbsp_pkg::CMD_FLUSH && r_len != '0, r_out_vld && r_out_last && r_len == '0, "flush byte not issued")
    `NRBSP_ASSERT_NOW(a_flush_empty_hold, i_cmd.valid && i_cmd.kind == nrbsp_pkg::CMD_FLUSH, !r_hold_vld, "flush with a held byte")

endmodule

>>> sv/node_record_bit_stuffing_packer_unit.sv
// Top level of the node record bit stuffing packer.
// Each encode request sends its record one bit per clock unless the byte packer stalls: 3
// branch bits, 2 base code bits, the count's significant bits with a one stuffed after every
// third zero in a row, then four zeros; bytes go out MSB first. For a 32-bit count the count
// bits plus stuffed ones number at most 42. A new request is taken only when the sequencer
// is idle again. Output back pressure stalls the stream only when a completed byte waits on
// the output register. A zero count is sent as one and flagged in m_axis_tuser.
module node_record_bit_stuffing_packer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] branch_count, [10:3] label_char, [42:11] count_value, [47:43] zero
    input  logic [47:0] s_axis_tdata,
    // [0] req_type
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_byte
    output logic [7:0]  m_axis_tdata,
    // [0] bad_count
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);

    nrbsp_pkg::t_pk_cmd w_cmd;
    logic               w_cmd_ready;

    // Record sequencer
    nrbsp_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (s_axis_tvalid),
        .o_s_ready   (s_axis_tready),
        .i_req_type  (s_axis_tuser),
        .i_branch    (s_axis_tdata[2:0]),
        .i_label     (s_axis_tdata[10:3]),
        .i_count     (s_axis_tdata[42:11]),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    // Byte packer and output register
    nrbsp_pack u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .o_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .o_m_byte    (m_axis_tdata),
        .o_m_last    (m_axis_tlast),
        .o_m_bad     (m_axis_tuser)
    );

endmodule
